>>> hw/rtl/tlvgp_pkg.sv
// Package for the TLV group parser: result word type and status codes.
// No dependencies; imported by every module of the block.
`default_nettype none

package tlvgp_pkg;

  localparam int unsigned DATA_W = 32;

  // Byte address of the search register; word index is paddr[2].
  localparam logic ADDR_SEARCH_TAG = 1'b0;

  localparam logic [7:0] TAG_LOW_ALL = 8'h1F;
  localparam logic [7:0] MORE_BIT    = 8'h80;
  localparam logic [6:0] COUNT_MASK  = 7'h7F;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_TAG  = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_STOPPED  = 3'd4,
    ST_TOO_LONG = 3'd5
  } tlvgp_status_t;

  typedef struct packed {
    logic [31:0]   tag_value;
    logic [31:0]   value_length;
    logic [15:0]   element_offset;
    logic [3:0]    header_bytes;
    logic [15:0]   element_index;
    logic          tag_matches;
    logic          group_done;
    tlvgp_status_t status;
  } tlvgp_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/tlvgp_cfg.sv
// APB-style register file holding the search tag.
// Uses tlvgp_pkg for the register address.
`default_nettype none

module tlvgp_cfg
  import tlvgp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [31:0] search_tag
);

  logic [31:0] search_tag_r;
  logic        wr_search;

  assign pready    = 1'b1;
  assign wr_search = psel && penable && pwrite && (paddr[2] == ADDR_SEARCH_TAG);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_tag_r <= '0;
    end else if (wr_search) begin
      search_tag_r <= pwdata;
    end
  end

  assign prdata     = (paddr[2] == ADDR_SEARCH_TAG) ? search_tag_r : '0;
  assign search_tag = search_tag_r;

endmodule

`default_nettype wire

>>> hw/rtl/tlvgp_walker.sv
// Element walker: per-byte TLV decode state and the result word for one byte.
// Uses tlvgp_pkg for the result type and status codes.
`default_nettype none

module tlvgp_walker
  import tlvgp_pkg::*;
#(
  parameter int unsigned MAX_TAG_BYTES   = 4,
  parameter int unsigned MAX_LEN_BYTES   = 4,
  parameter int unsigned MAX_GROUP_BYTES = 65536
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  input  wire logic [31:0]   search_tag,
  output logic               res_valid,
  output tlvgp_result_t      res
);

  localparam int unsigned TAG_W     = 8 * MAX_TAG_BYTES;
  localparam int unsigned LEN_W     = 8 * MAX_LEN_BYTES;
  localparam int unsigned POS_W     = $clog2(MAX_GROUP_BYTES + 1);
  localparam int unsigned TCNT_W    = $clog2(MAX_TAG_BYTES + 1);
  localparam int unsigned LLEFT_W   = $clog2(MAX_LEN_BYTES + 1);

  typedef enum logic [2:0] {
    PH_TAG_START,
    PH_TAG_MORE,
    PH_LEN_FIRST,
    PH_LEN_MORE,
    PH_VALUE
  } phase_t;

  phase_t              phase_r,      phase_nxt;
  logic [TAG_W-1:0]    tag_accum_r,  tag_accum_nxt;
  logic [TCNT_W-1:0]   tag_cnt_r,    tag_cnt_nxt;
  logic [LEN_W-1:0]    len_accum_r,  len_accum_nxt;
  logic [LLEFT_W-1:0]  len_left_r,   len_left_nxt;
  logic [LEN_W-1:0]    val_left_r,   val_left_nxt;
  logic [POS_W-1:0]    pos_r,        pos_nxt;
  logic [15:0]         elem_start_r, elem_start_nxt;
  logic [3:0]          hdr_cnt_r,    hdr_cnt_nxt;
  logic [15:0]         elem_seen_r,  elem_seen_nxt;
  logic                stopped_r,    stopped_nxt;

  tlvgp_status_t       err;
  logic                complete;
  logic                new_group;
  logic [6:0]          cnt_n;
  logic [LEN_W-1:0]    val_dec;
  logic [LLEFT_W-1:0]  left_dec;
  logic [31:0]         tag_out;

  assign cnt_n    = data_byte[6:0] & COUNT_MASK;
  assign val_dec  = (val_left_r != '0) ? val_left_r - LEN_W'(1) : val_left_r;
  assign left_dec = (len_left_r != '0) ? len_left_r - LLEFT_W'(1) : len_left_r;

  always_comb begin
    phase_nxt      = phase_r;
    tag_accum_nxt  = tag_accum_r;
    tag_cnt_nxt    = tag_cnt_r;
    len_accum_nxt  = len_accum_r;
    len_left_nxt   = len_left_r;
    val_left_nxt   = val_left_r;
    pos_nxt        = pos_r;
    elem_start_nxt = elem_start_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    elem_seen_nxt  = elem_seen_r;
    stopped_nxt    = stopped_r;
    err            = ST_OK;
    complete       = 1'b0;

    if (!stopped_r) begin
      if (pos_r >= POS_W'(MAX_GROUP_BYTES)) begin
        err = ST_TOO_LONG;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        case (phase_r)
          PH_TAG_START: begin
            if (data_byte == 8'h00) begin
              err = ST_BAD_TAG;
            end else begin
              elem_start_nxt = 16'(pos_r);
              tag_accum_nxt  = TAG_W'(data_byte);
              tag_cnt_nxt    = TCNT_W'(1);
              hdr_cnt_nxt    = 4'd1;
              len_accum_nxt  = '0;
              phase_nxt      = ((data_byte & TAG_LOW_ALL) == TAG_LOW_ALL) ?
                               PH_TAG_MORE : PH_LEN_FIRST;
            end
          end
          PH_TAG_MORE: begin
            if (tag_cnt_r >= TCNT_W'(MAX_TAG_BYTES)) begin
              err = ST_BAD_TAG;
            end else begin
              tag_cnt_nxt   = tag_cnt_r + TCNT_W'(1);
              hdr_cnt_nxt   = hdr_cnt_r + 4'd1;
              tag_accum_nxt = (tag_accum_r << 8) | TAG_W'(data_byte);
              if ((data_byte & MORE_BIT) == 8'h00) begin
                phase_nxt = PH_LEN_FIRST;
              end
            end
          end
          PH_LEN_FIRST: begin
            hdr_cnt_nxt = hdr_cnt_r + 4'd1;
            if ((data_byte & MORE_BIT) == 8'h00) begin
              len_accum_nxt = LEN_W'(data_byte);
              if (data_byte == 8'h00) begin
                complete = 1'b1;
              end else begin
                val_left_nxt = LEN_W'(data_byte);
                phase_nxt    = PH_VALUE;
              end
            end else if (cnt_n == 7'd0 || cnt_n == COUNT_MASK ||
                         32'(cnt_n) > MAX_LEN_BYTES) begin
              err = ST_BAD_LEN;
            end else begin
              len_accum_nxt = '0;
              len_left_nxt  = LLEFT_W'(cnt_n);
              phase_nxt     = PH_LEN_MORE;
            end
          end
          PH_LEN_MORE: begin
            hdr_cnt_nxt   = hdr_cnt_r + 4'd1;
            len_accum_nxt = (len_accum_r << 8) | LEN_W'(data_byte);
            len_left_nxt  = left_dec;
            if (left_dec == '0) begin
              if (len_accum_nxt == '0) begin
                complete = 1'b1;
              end else begin
                val_left_nxt = len_accum_nxt;
                phase_nxt    = PH_VALUE;
              end
            end
          end
          default: begin
            val_left_nxt = val_dec;
            if (val_dec == '0) begin
              complete = 1'b1;
            end
          end
        endcase
      end
    end

    // Result word for this byte
    tag_out       = 32'(tag_accum_nxt);
    res           = '0;
    res.element_index = elem_seen_r;
    res.group_done    = last_byte;
    res.status        = ST_OK;
    res_valid         = 1'b0;
    new_group         = 1'b0;

    if (stopped_r) begin
      if (last_byte) begin
        res_valid  = 1'b1;
        res.status = ST_STOPPED;
        new_group  = 1'b1;
      end
    end else if (err != ST_OK) begin
      res_valid  = 1'b1;
      res.status = err;
      if (last_byte) begin
        new_group = 1'b1;
      end else begin
        stopped_nxt = 1'b1;
      end
    end else if (complete) begin
      res_valid          = 1'b1;
      res.tag_value      = tag_out;
      res.value_length   = 32'(len_accum_nxt);
      res.element_offset = elem_start_nxt;
      res.header_bytes   = hdr_cnt_nxt;
      res.tag_matches    = (tag_out == search_tag);
      elem_seen_nxt      = elem_seen_r + 16'd1;
      phase_nxt          = PH_TAG_START;
      new_group          = last_byte;
    end else if (last_byte) begin
      res_valid  = 1'b1;
      res.status = ST_TRUNC;
      new_group  = 1'b1;
    end

    if (new_group) begin
      phase_nxt     = PH_TAG_START;
      tag_cnt_nxt   = '0;
      len_left_nxt  = '0;
      val_left_nxt  = '0;
      pos_nxt       = '0;
      elem_seen_nxt = '0;
      stopped_nxt   = 1'b0;
    end

    if (!step) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TAG_START;
      tag_cnt_r   <= '0;
      len_left_r  <= '0;
      val_left_r  <= '0;
      pos_r       <= '0;
      elem_seen_r <= '0;
      stopped_r   <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      tag_cnt_r   <= tag_cnt_nxt;
      len_left_r  <= len_left_nxt;
      val_left_r  <= val_left_nxt;
      pos_r       <= pos_nxt;
      elem_seen_r <= elem_seen_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

  // Element header payload; rewritten on a nonzero first tag byte that starts an element
  always_ff @(posedge clk) begin
    if (step) begin
      tag_accum_r  <= tag_accum_nxt;
      len_accum_r  <= len_accum_nxt;
      elem_start_r <= elem_start_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tlvgp_out_reg.sv
// Result register: holds one result word until the consumer takes it.
// Uses tlvgp_pkg for the result type.
`default_nettype none

module tlvgp_out_reg
  import tlvgp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          res_valid,
  input  wire tlvgp_result_t res,
  input  wire logic          out_stall,
  output logic               advance,
  output logic               out_valid,
  output tlvgp_result_t      out_res
);

  logic          out_valid_r;
  tlvgp_result_t out_res_r;

  // Register can load when empty or when its word leaves this cycle
  assign advance = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

>>> hw/rtl/ber_tlv_group_parser.sv
// Top level of the BER-TLV group parser: input register, walker, result register.
// Depends on tlvgp_pkg, tlvgp_cfg, tlvgp_walker and tlvgp_out_reg.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+------------------------------------------
//   in_     | in        | in_valid/in_stall  | data_byte, last_byte
//   out_    | out       | out_valid/out_stall| tag, length, offset, header, index, status
//   apb     | in        | psel/penable/pready| search_tag at byte address 0
//
// One byte per clock while the result side does not stall. A word in the input register
// is decoded there and its result (if any) is registered in the result register, which
// drives out_valid. The walker's per-byte decode sets the rate.
// Synchronous active-low reset clears the walker state and both valid flags.
// A stalled result holds the input register, which then stalls the input side.
`default_nettype none

module ber_tlv_group_parser
  import tlvgp_pkg::*;
#(
  parameter int unsigned MAX_TAG_BYTES   = 4,
  parameter int unsigned MAX_LEN_BYTES   = 4,
  parameter int unsigned MAX_GROUP_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input words
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  // result words
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_tag_value,
  output logic [31:0]      out_value_length,
  output logic [15:0]      out_element_offset,
  output logic [3:0]       out_header_bytes,
  output logic [15:0]      out_element_index,
  output logic             out_tag_matches,
  output logic             out_group_done,
  output logic [2:0]       out_status,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;
  logic          s1_last_r;
  logic          advance;
  logic          step;
  logic          res_valid;
  tlvgp_result_t res;
  tlvgp_result_t out_res;
  logic [31:0]   search_tag;

  // Input register: refills whenever its word moves on (or it is empty)
  assign in_stall = s1_valid_r && !advance;
  assign step     = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  tlvgp_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .search_tag (search_tag)
  );

  tlvgp_walker #(
    .MAX_TAG_BYTES   (MAX_TAG_BYTES),
    .MAX_LEN_BYTES   (MAX_LEN_BYTES),
    .MAX_GROUP_BYTES (MAX_GROUP_BYTES)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data_byte  (s1_byte_r),
    .last_byte  (s1_last_r),
    .search_tag (search_tag),
    .res_valid  (res_valid),
    .res        (res)
  );

  tlvgp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .advance   (advance),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_tag_value      = out_res.tag_value;
  assign out_value_length   = out_res.value_length;
  assign out_element_offset = out_res.element_offset;
  assign out_header_bytes   = out_res.header_bytes;
  assign out_element_index  = out_res.element_index;
  assign out_tag_matches    = out_res.tag_matches;
  assign out_group_done     = out_res.group_done;
  assign out_status         = out_res.status;

endmodule

`default_nettype wire
